// ===== design/swmd_pkg.sv =====
`timescale 1ns / 1ps

package swmd_pkg;

    // Fixed widths of the transaction fields.
    localparam int REQ_W   = 2;
    localparam int WORD_W  = 32;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 5;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH   = 2'd0,
        REQ_POP    = 2'd1,
        REQ_DELETE = 2'd2,
        REQ_READ   = 2'd3
    } t_req;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE      = 2'd0,
        ST_UNDERFLOW = 2'd1,
        ST_OVERFLOW  = 2'd2
    } t_status;

    // What a storage cell does on the next clock edge.
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_FROM_ABOVE,
        CELL_FROM_BELOW
    } t_cell_cmd;

    // How the whole row of cells moves for one request.
    typedef enum logic [1:0] {
        SH_NONE,
        SH_PUSH,
        SH_POP,
        SH_DELETE
    } t_shift;

endpackage

// ===== design/swmd_if.sv =====
`timescale 1ns / 1ps

interface swmd_req_if;
    logic                              valid;
    logic                              ready;
    logic [swmd_pkg::REQ_W-1:0]        req_type;
    logic signed [swmd_pkg::WORD_W-1:0] push_value;

    modport source (output valid, output req_type, output push_value, input ready);
    modport sink   (input valid, input req_type, input push_value, output ready);
endinterface

interface swmd_rsp_if;
    logic                               valid;
    logic                               ready;
    logic [swmd_pkg::STAT_W-1:0]        status;
    logic [swmd_pkg::COUNT_W-1:0]       entry_count;
    logic signed [swmd_pkg::WORD_W-1:0] top_value;
    logic signed [swmd_pkg::WORD_W-1:0] middle_value;

    modport source (
        output valid, output status, output entry_count,
        output top_value, output middle_value, input ready
    );
    modport sink (
        input valid, input status, input entry_count,
        input top_value, input middle_value, output ready
    );
endinterface

// ===== design/swmd_cell.sv =====
`timescale 1ns / 1ps

// One stack entry. It keeps its word, or takes the word of the cell above or below.
module swmd_cell #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                   i_clk,
    input  swmd_pkg::t_cell_cmd    i_cmd,
    input  logic [DATA_WIDTH-1:0]  i_above,
    input  logic [DATA_WIDTH-1:0]  i_below,
    output logic [DATA_WIDTH-1:0]  o_data
);

    logic [DATA_WIDTH-1:0] r_data;
    logic [DATA_WIDTH-1:0] n_data;

    always_comb begin
        unique case (i_cmd)
            swmd_pkg::CELL_FROM_ABOVE: n_data = i_above;
            swmd_pkg::CELL_FROM_BELOW: n_data = i_below;
            default:                   n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

// ===== design/stack_with_middle_delete.sv =====
`timescale 1ns / 1ps

// Bounded LIFO stack of signed words that can also read and delete its middle
// entry, the one at position floor(count/2) counted from the top (the top is
// position 0). Each request transaction is a push, a pop, a middle delete or a
// plain read, and each one yields exactly one response transaction carrying a
// status (done, underflow on an empty stack, overflow on a push onto a full
// stack), the entry count after the request and the new top and middle words,
// both zero when the stack is empty. The entries live in a row of DEPTH
// identical cells ordered from the top: a push moves every cell one place
// down, a pop moves every cell one place up, and a middle delete moves up only
// the cells from the middle position downwards, all at the same clock edge.
// The block therefore sustains one request per clock cycle as long as the
// responses are taken as they appear. A taken request first enters the
// internal result stage, and its response moves on into the output register
// once that register is free or is being emptied. A held response stalls new
// requests only once the internal result stage is also occupied. Stored
// words are DATA_WIDTH bits wide; pushed words are sign-extended or truncated
// to that width and read back sign-extended to 32 bits. No clearing pass is
// needed after reset, as only live entries are read.
module stack_with_middle_delete #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    swmd_req_if.sink       i_req,
    swmd_rsp_if.source     o_rsp
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

    // Request decode.
    swmd_pkg::t_req    req;
    logic              accept;
    logic              empty;
    logic              full;
    swmd_pkg::t_status n_status;
    swmd_pkg::t_shift  shift;
    logic [CNT_W-1:0]  n_count;
    logic [CNT_W-1:0]  mid_pos;

    // Stack state.
    logic [CNT_W-1:0]  r_count;

    // Result stage: the request has been applied and its response is still to
    // be captured from the updated cells.
    logic              r_pend;
    swmd_pkg::t_status r_pend_status;
    logic              move;

    // Output register.
    logic                                r_out_valid;
    logic [swmd_pkg::STAT_W-1:0]         r_status;
    logic [swmd_pkg::COUNT_W-1:0]        r_entry_count;
    logic signed [swmd_pkg::WORD_W-1:0]  r_top;
    logic signed [swmd_pkg::WORD_W-1:0]  r_mid;

    logic [DATA_WIDTH-1:0] push_word;
    logic [DATA_WIDTH-1:0] cell_data [DEPTH];
    logic [DEPTH-1:0]      mid_sel;
    logic [DATA_WIDTH-1:0] top_word;
    logic [DATA_WIDTH-1:0] mid_word;

    assign req       = swmd_pkg::t_req'(i_req.req_type);
    assign accept    = i_req.valid && i_req.ready;
    assign empty     = (r_count == '0);
    assign full      = (r_count == FULL_COUNT);
    assign mid_pos   = r_count >> 1;
    assign push_word = DATA_WIDTH'(i_req.push_value);

    // The response moves to the output register when that register is free
    // or is being emptied, and a new request may enter whenever the result
    // stage is free or is being emptied.
    assign move        = r_pend && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_pend || move;

    // Work out the status and how the cell row shifts for this request.
    always_comb begin
        n_status = swmd_pkg::ST_DONE;
        shift    = swmd_pkg::SH_NONE;
        n_count  = r_count;
        priority if (req == swmd_pkg::REQ_PUSH) begin
            if (full) begin
                n_status = swmd_pkg::ST_OVERFLOW;
            end else begin
                shift   = swmd_pkg::SH_PUSH;
                n_count = r_count + CNT_W'(1);
            end
        end else if (empty) begin
            n_status = swmd_pkg::ST_UNDERFLOW;
        end else if (req == swmd_pkg::REQ_POP) begin
            shift   = swmd_pkg::SH_POP;
            n_count = r_count - CNT_W'(1);
        end else if (req == swmd_pkg::REQ_DELETE) begin
            shift   = swmd_pkg::SH_DELETE;
            n_count = r_count - CNT_W'(1);
        end else begin
            shift = swmd_pkg::SH_NONE;
        end
    end

    // The row of cells, top of stack in cell 0. Each cell chooses its own
    // move: on a middle delete only the cells at or below the middle position
    // take the word of their lower neighbour, which closes the gap.
    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        swmd_pkg::t_cell_cmd   cmd;
        logic [DATA_WIDTH-1:0] above;
        logic [DATA_WIDTH-1:0] below;

        always_comb begin
            cmd = swmd_pkg::CELL_HOLD;
            if (accept) begin
                unique case (shift)
                    swmd_pkg::SH_PUSH:   cmd = swmd_pkg::CELL_FROM_ABOVE;
                    swmd_pkg::SH_POP:    cmd = swmd_pkg::CELL_FROM_BELOW;
                    swmd_pkg::SH_DELETE: cmd = (CNT_W'(k) >= mid_pos) ?
                                               swmd_pkg::CELL_FROM_BELOW :
                                               swmd_pkg::CELL_HOLD;
                    default:             cmd = swmd_pkg::CELL_HOLD;
                endcase
            end
        end

        if (k == 0) begin : g_first
            assign above = push_word;
        end else begin : g_inner_above
            assign above = cell_data[k-1];
        end

        if (k == DEPTH - 1) begin : g_last
            assign below = cell_data[k];
        end else begin : g_inner_below
            assign below = cell_data[k+1];
        end

        // The middle of the current contents, as a one-hot mark over the row.
        assign mid_sel[k] = !empty && (CNT_W'(k) == mid_pos);

        swmd_cell #(
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .i_clk   (i_clk),
            .i_cmd   (cmd),
            .i_above (above),
            .i_below (below),
            .o_data  (cell_data[k])
        );
    end

    // Top and middle of the stack as it stands; zero when empty.
    always_comb begin
        top_word = empty ? '0 : cell_data[0];
        mid_word = '0;
        for (int k = 0; k < DEPTH; k++) begin
            mid_word = mid_word | (mid_sel[k] ? cell_data[k] : '0);
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count <= n_count;
            end
            if (accept) begin
                r_pend <= 1'b1;
            end else if (move) begin
                r_pend <= 1'b0;
            end
            if (move) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers. The cells and the count take the stack after a request
    // at the same edge as the result stage is loaded, and no later request
    // changes them before the output register samples them.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pend_status <= n_status;
        end
        if (move) begin
            r_status      <= r_pend_status;
            r_entry_count <= swmd_pkg::COUNT_W'(r_count);
            r_top         <= swmd_pkg::WORD_W'(signed'(top_word));
            r_mid         <= swmd_pkg::WORD_W'(signed'(mid_word));
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.status       = r_status;
    assign o_rsp.entry_count  = r_entry_count;
    assign o_rsp.top_value    = r_top;
    assign o_rsp.middle_value = r_mid;

endmodule

// ===== design/swmd_checker.sv =====
`timescale 1ns / 1ps

module swmd_checker #(
    parameter int DEPTH = 16
) (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_rsp_valid,
    input logic                               i_rsp_ready,
    input logic [swmd_pkg::STAT_W-1:0]        i_status,
    input logic [swmd_pkg::COUNT_W-1:0]       i_entry_count,
    input logic signed [swmd_pkg::WORD_W-1:0] i_top_value,
    input logic signed [swmd_pkg::WORD_W-1:0] i_middle_value
);

    localparam logic [swmd_pkg::COUNT_W-1:0] FULL_TRUNC = swmd_pkg::COUNT_W'(DEPTH);

    // An empty stack shows zero for both words.
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && i_entry_count == '0) |-> (i_top_value == '0 && i_middle_value == '0))
        else $error("empty stack shows a non-zero word");

    // With one entry the middle is the top.
    a_single_mid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && i_entry_count == swmd_pkg::COUNT_W'(1)) |->
        (i_top_value == i_middle_value))
        else $error("single entry: middle differs from top");

    // Underflow only happens on an empty stack.
    a_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && i_status == swmd_pkg::ST_UNDERFLOW) |-> (i_entry_count == '0))
        else $error("underflow reported on a stack that holds entries");

    // Overflow only happens on a full stack.
    a_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && i_status == swmd_pkg::ST_OVERFLOW) |-> (i_entry_count == FULL_TRUNC))
        else $error("overflow reported on a stack that is not full");

    // A stalled response transaction stays put.
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=>
        (i_rsp_valid && $stable(i_status) && $stable(i_entry_count) &&
         $stable(i_top_value) && $stable(i_middle_value)))
        else $error("stalled response changed");

endmodule

bind stack_with_middle_delete swmd_checker #(
    .DEPTH (DEPTH)
) u_swmd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_rsp_valid    (o_rsp.valid),
    .i_rsp_ready    (o_rsp.ready),
    .i_status       (o_rsp.status),
    .i_entry_count  (o_rsp.entry_count),
    .i_top_value    (o_rsp.top_value),
    .i_middle_value (o_rsp.middle_value)
);
